>>> design/icmp_echo_reply_classifier_assert.svh
// Assertion macros shared by the classifier RTL.
`ifndef ICMP_ECHO_REPLY_CLASSIFIER_ASSERT_SVH
`define ICMP_ECHO_REPLY_CLASSIFIER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IECR_ASSERT_SAME(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("iecr: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define IECR_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("iecr: next-cycle check failed");

`endif

>>> design/iecr_pkg.sv
package iecr_pkg;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_SUCCESS     = 4'd0,
    ST_NET_UNR     = 4'd1,
    ST_HOST_UNR    = 4'd2,
    ST_PROTO_UNR   = 4'd3,
    ST_PORT_UNR    = 4'd4,
    ST_TOO_BIG     = 4'd5,
    ST_BAD_ROUTE   = 4'd6,
    ST_TTL_TRANSIT = 4'd7,
    ST_TTL_REASM   = 4'd8,
    ST_PARAM       = 4'd9,
    ST_QUENCH      = 4'd10,
    ST_FAILURE     = 4'd11
  } status_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_EXPECTED_ID  = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_SEQ = 2'd1;
  localparam logic [1:0] CFG_PING_MODE    = 2'd2;

  // Protocol codes.
  localparam logic [3:0] IP_VERSION4        = 4'd4;
  localparam logic [7:0] IP_PROTO_ICMP      = 8'd1;
  localparam logic [7:0] ICMP_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] ICMP_DEST_UNREACH  = 8'd3;
  localparam logic [7:0] ICMP_SOURCE_QUENCH = 8'd4;
  localparam logic [7:0] ICMP_ECHO_REQUEST  = 8'd8;
  localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] ICMP_PARAM_PROBLEM = 8'd12;
  localparam logic [7:0] ICMP_CODE_REASM    = 8'd1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
    logic       truncated;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    status_e     status;
    logic [10:0] data_size;
    logic [7:0]  ttl;
    logic [7:0]  tos;
    logic [2:0]  frag_flags;
    logic [5:0]  options_size;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  addr;
    logic [15:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic [15:0] expected_id;
    logic [15:0] expected_seq;
    logic        ping_mode;
  } cfg_regs_t;

  // Per-datagram captured fields (the byte counter lives beside it).
  typedef struct packed {
    logic [5:0]  header_len;
    logic [7:0]  reply_ttl;
    logic [7:0]  reply_tos;
    logic [2:0]  reply_flags;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
    logic [5:0]  inner_header_len;
    logic        checks_ok;
    logic        inner_ok;
  } frame_t;

  localparam frame_t FRAME_CLEAR = '{
    header_len: 6'd0, reply_ttl: 8'd0, reply_tos: 8'd0, reply_flags: 3'd0,
    icmp_type: 8'd0, icmp_code: 8'd0, echo_id: 16'd0, echo_seq: 16'd0,
    inner_header_len: 6'd0, checks_ok: 1'b1, inner_ok: 1'b1
  };

  localparam cfg_regs_t CFG_RESET = '{
    expected_id: 16'd0, expected_seq: 16'd0, ping_mode: 1'b0
  };

  // Destination-unreachable code to status.
  function automatic status_e unreach_status(input logic [7:0] code);
    status_e s;
    unique case (code)
      8'd0, 8'd6, 8'd9, 8'd11: s = ST_NET_UNR;
      8'd2:                    s = ST_PROTO_UNR;
      8'd3:                    s = ST_PORT_UNR;
      8'd4:                    s = ST_TOO_BIG;
      8'd5:                    s = ST_BAD_ROUTE;
      default:                 s = ST_HOST_UNR;
    endcase
    return s;
  endfunction

endpackage

>>> design/iecr_chan_if.sv
interface iecr_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/iecr_classify.sv
module iecr_classify #(
  parameter int CW = 12
) (
  input  logic [CW-1:0]       count,
  input  iecr_pkg::frame_t    frame,
  input  iecr_pkg::cfg_regs_t cfg,
  input  logic                truncated,
  output iecr_pkg::out_item_t result
);
  import iecr_pkg::*;

  localparam int PW = CW + 2;
  localparam int DW = (CW > 11) ? CW : 11;
  localparam logic [DW-1:0] DS_MAX = DW'(2047);

  logic          raw;
  logic          ok;
  logic          hit;
  logic          trunc_fail;
  logic [PW-1:0] n;
  logic [PW-1:0] h;
  logic [PW-1:0] inl;
  logic [PW-1:0] diff;
  logic [DW-1:0] ds_w;
  logic [10:0]   ds;
  logic [10:0]   ds_out;
  status_e       status;

  always_comb begin
    raw  = !cfg.ping_mode;
    n    = PW'(count);
    h    = PW'(frame.header_len);
    inl  = PW'(frame.inner_header_len);
    ok   = n >= h + PW'(8);
    if (raw) begin
      ok = ok && (n >= PW'(20)) && (h >= PW'(20)) && frame.checks_ok;
    end
    diff = n - h - PW'(8);
    ds_w = DW'(diff[CW-1:0]);
    ds   = (ds_w > DS_MAX) ? 11'h7ff : ds_w[10:0];

    hit        = 1'b0;
    trunc_fail = 1'b0;
    ds_out     = 11'd0;
    status     = ST_SUCCESS;
    if (ok) begin
      unique case (frame.icmp_type)
        ICMP_ECHO_REPLY: begin
          if (!(raw && frame.echo_id != cfg.expected_id) &&
              frame.echo_seq == cfg.expected_seq) begin
            if (ds != 11'd0 && truncated) begin
              trunc_fail = 1'b1;
            end else begin
              hit    = 1'b1;
              ds_out = ds;
            end
          end
        end
        ICMP_DEST_UNREACH: begin
          hit    = 1'b1;
          status = unreach_status(frame.icmp_code);
        end
        ICMP_TIME_EXCEEDED: begin
          hit    = 1'b1;
          status = (frame.icmp_code == ICMP_CODE_REASM) ? ST_TTL_REASM : ST_TTL_TRANSIT;
        end
        ICMP_PARAM_PROBLEM: begin
          hit    = 1'b1;
          status = ST_PARAM;
        end
        ICMP_SOURCE_QUENCH: begin
          hit    = 1'b1;
          status = ST_QUENCH;
        end
        default: hit = 1'b0;
      endcase
    end

    // Error messages in raw mode must carry our original request's IP header and ICMP header.
    if (hit && raw && frame.icmp_type != ICMP_ECHO_REPLY) begin
      if (n < h + PW'(28) || n < h + PW'(16) + inl || !frame.inner_ok) begin
        hit = 1'b0;
      end
    end

    result = '0;
    if (trunc_fail) begin
      result.accepted = 1'b1;
      result.status   = ST_FAILURE;
    end else if (hit) begin
      result.accepted  = 1'b1;
      result.status    = status;
      result.data_size = ds_out;
      if (raw) begin
        result.ttl          = frame.reply_ttl;
        result.tos          = frame.reply_tos;
        result.frag_flags   = frame.reply_flags;
        result.options_size = frame.header_len - 6'd20;
      end
    end
  end

endmodule

>>> design/icmp_echo_reply_classifier.sv
// Channel   Dir  Payload                                        Transaction
// in_ch     in   rx_byte, last_byte, truncated                  one datagram byte
// out_ch    out  accepted, status, data_size, ttl, tos,         one verdict per datagram
//                frag_flags, options_size
// cfg_ch    in   addr, wdata                                    one register write
//
// One byte is taken per cycle while the input does not stall. A byte sits in the input
// register while the captured fields are updated; on the last byte the verdict is formed in
// that same cycle and lands in the result register that drives out_ch. Reset is
// synchronous and returns the frame state and the configuration to their defaults. The
// input stalls only when a last byte waits in the input register behind a verdict that
// out_ch has not yet taken.
`include "icmp_echo_reply_classifier_assert.svh"

module icmp_echo_reply_classifier #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input logic         clk,
  input logic         rst,
  iecr_chan_if.sink   in_ch,
  iecr_chan_if.source out_ch,
  iecr_chan_if.sink   cfg_ch
);
  import iecr_pkg::*;

  // The byte counter must be able to hold MAX_PACKET_BYTES itself, where it stops.
  localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
  // Positions are compared with room for header offsets of well over a hundred bytes.
  localparam int PW = CW + 2;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PACKET_BYTES);

  // Configuration registers.
  cfg_regs_t cfg;

  // Input register.
  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_adv;

  // Frame state and its per-byte update.
  logic [CW-1:0] byte_count;
  logic [CW-1:0] byte_count_next;
  frame_t        fr;
  frame_t        fr_next;
  logic [PW-1:0] p;
  logic [PW-1:0] h;
  logic [PW-1:0] j;
  logic [7:0]    b;
  logic          raw;

  // Result register.
  logic      out_valid;
  out_item_t out_item;
  out_item_t cls_res;
  logic      in_accept;
  logic      out_load;

  // A byte leaves the input register unless it is a last byte whose verdict has
  // nowhere to go yet.
  assign s1_adv    = s1_valid && (!s1_item.last_byte || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_load  = s1_adv && s1_item.last_byte;

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;
  assign cfg_ch.ready = 1'b1;

  // Field capture for the byte at position byte_count. A short IHL can put one byte at
  // several field positions, so every comparison is made independently. The header
  // length and the inner header length are used as soon as they are captured.
  always_comb begin
    raw             = !cfg.ping_mode;
    b               = s1_item.rx_byte;
    p               = PW'(byte_count);
    fr_next         = fr;
    byte_count_next = byte_count;
    h               = PW'(fr.header_len);
    j               = '0;
    if (byte_count < COUNT_MAX) begin
      if (p == PW'(0)) begin
        fr_next.header_len = raw ? {b[3:0], 2'b00} : 6'd0;
        if (raw && b[7:4] != IP_VERSION4) begin
          fr_next.checks_ok = 1'b0;
        end
      end
      if (raw && p == PW'(9) && b != IP_PROTO_ICMP) begin
        fr_next.checks_ok = 1'b0;
      end
      if (p == PW'(1)) fr_next.reply_tos = b;
      if (p == PW'(6)) fr_next.reply_flags = b[7:5];
      if (p == PW'(8)) fr_next.reply_ttl = b;

      h = PW'(fr_next.header_len);
      if (p == h)          fr_next.icmp_type = b;
      if (p == h + PW'(1)) fr_next.icmp_code = b;
      if (p == h + PW'(4)) fr_next.echo_id[15:8] = b;
      if (p == h + PW'(5)) fr_next.echo_id[7:0] = b;
      if (p == h + PW'(6)) fr_next.echo_seq[15:8] = b;
      if (p == h + PW'(7)) fr_next.echo_seq[7:0] = b;

      // The embedded original datagram starts right after the 8-byte ICMP header.
      if (p == h + PW'(8)) begin
        fr_next.inner_header_len = {b[3:0], 2'b00};
        if (b[7:4] != IP_VERSION4) fr_next.inner_ok = 1'b0;
      end
      if (p == h + PW'(17) && b != IP_PROTO_ICMP) fr_next.inner_ok = 1'b0;

      // Our echo request's ICMP header inside the embedded datagram.
      j = h + PW'(8) + PW'(fr_next.inner_header_len);
      if (p == j && b != ICMP_ECHO_REQUEST) fr_next.inner_ok = 1'b0;
      if (p == j + PW'(1) && b != 8'd0) fr_next.inner_ok = 1'b0;
      if (p == j + PW'(4) && b != cfg.expected_id[15:8]) fr_next.inner_ok = 1'b0;
      if (p == j + PW'(5) && b != cfg.expected_id[7:0]) fr_next.inner_ok = 1'b0;
      if (p == j + PW'(6) && b != cfg.expected_seq[15:8]) fr_next.inner_ok = 1'b0;
      if (p == j + PW'(7) && b != cfg.expected_seq[7:0]) fr_next.inner_ok = 1'b0;

      byte_count_next = byte_count + 1'b1;
    end
  end

  // The verdict sees the frame state including the last byte itself.
  iecr_classify #(
    .CW(CW)
  ) u_classify (
    .count     (byte_count_next),
    .frame     (fr_next),
    .cfg       (cfg),
    .truncated (s1_item.truncated),
    .result    (cls_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      byte_count <= '0;
      fr         <= FRAME_CLEAR;
      cfg        <= CFG_RESET;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        if (s1_item.last_byte) begin
          byte_count <= '0;
          fr         <= FRAME_CLEAR;
        end else begin
          byte_count <= byte_count_next;
          fr         <= fr_next;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_ch.valid) begin
        unique case (cfg_ch.data.addr)
          CFG_EXPECTED_ID:  cfg.expected_id  <= cfg_ch.data.wdata;
          CFG_EXPECTED_SEQ: cfg.expected_seq <= cfg_ch.data.wdata;
          CFG_PING_MODE:    cfg.ping_mode    <= cfg_ch.data.wdata[0];
          default:          cfg              <= cfg;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= in_ch.data;
    end
    if (out_load) begin
      out_item <= cls_res;
    end
  end

  // A skipped datagram reports nothing but zeros.
  `IECR_ASSERT_SAME(a_skip_zero, clk, rst, out_valid && !out_item.accepted, out_item == '0)

  // The truncation failure never reports a payload size.
  `IECR_ASSERT_SAME(a_fail_no_size, clk, rst, out_valid && out_item.status == ST_FAILURE,
                    out_item.data_size == 11'd0)

  // A last byte blocked behind an untaken verdict holds off new input.
  `IECR_ASSERT_SAME(a_last_blocks, clk, rst,
                    s1_valid && s1_item.last_byte && out_valid && !out_ch.ready,
                    !in_ch.ready)

  // The frame starts over after every last byte.
  `IECR_ASSERT_NEXT(a_frame_restart, clk, rst, out_load,
                    byte_count == '0 && fr == FRAME_CLEAR && out_valid)

endmodule
